### hw/rtl/asef_pkg.sv
// ============================================================================
// asef_pkg
// Shared types and constants for the ADC scan / EMA filter block.
// ============================================================================
package asef_pkg;

    // Fixed field widths
    localparam int CH_W   = 5;   // converter channel number
    localparam int SH_W   = 5;   // shift amounts
    localparam int SMP_W  = 12;  // raw conversion result
    localparam int VAL_W  = 16;  // filtered value returned on reads
    localparam int AVG_W  = 31;  // per-channel running average

    // Sample is aligned to the top of the average word
    localparam int SAMPLE_SHIFT = 19;

    // Reset values of the shift tables
    localparam logic [SH_W-1:0] FSH_RESET = 5'd9;
    localparam logic [SH_W-1:0] OSH_RESET = 5'd16;

    // Function codes carried in tuser
    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_SAMPLE = 2'd1,
        FUNC_READ   = 2'd2
    } t_func;

    // Decoded operation, already qualified by the pipeline advance
    typedef struct packed {
        logic            add;
        logic            sample;
        logic            rd;
        logic [CH_W-1:0] channel;
        logic [SH_W-1:0] filter_shift;
        logic [SH_W-1:0] out_shift;
    } t_op;

    // Scan table status toward the channel store and result register
    typedef struct packed {
        logic            add_ok;
        logic            refused;
        logic            sample_go;
        logic [CH_W-1:0] cur_channel;
        logic [SH_W-1:0] cur_filter_shift;
        logic [CH_W-1:0] next_channel;
    } t_scan_stat;

endpackage

### hw/rtl/asef_scan_table.sv
// ============================================================================
// asef_scan_table
// Scan slot table, slot count and round-robin slot pointer.
// ============================================================================
module asef_scan_table
    import asef_pkg::*;
#(
    parameter int SLOTS    = 18,
    parameter int CHANNELS = 18
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_op        i_op,
    output t_scan_stat o_stat
);

    localparam int PW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNTW = $clog2(SLOTS + 1);
    localparam int XW   = CNTW + 1;

    logic [CH_W-1:0] r_slot_ch  [SLOTS];
    logic [SH_W-1:0] r_slot_fsh [SLOTS];
    logic [CNTW-1:0] r_count;
    logic [PW-1:0]   r_ptr;
    logic [CH_W-1:0] r_cur_ch;   // mirror of slot channel at r_ptr

    logic            w_ch_ok;
    logic            w_add_ok;
    logic            w_go;
    logic [XW-1:0]   w_ptr_p1;
    logic [PW-1:0]   w_ptr_wrap;
    logic [PW-1:0]   n_ptr;
    logic [CNTW-1:0] n_count;
    logic [CH_W-1:0] n_cur_ch;

    always_comb begin
        w_ch_ok    = {1'b0, i_op.channel} < (CH_W + 1)'(CHANNELS);
        w_add_ok   = i_op.add && (r_count < CNTW'(SLOTS)) && w_ch_ok;
        w_go       = i_op.sample && (r_count != '0);
        w_ptr_p1   = XW'(r_ptr) + XW'(1);
        w_ptr_wrap = (w_ptr_p1 >= XW'(r_count)) ? '0 : w_ptr_p1[PW-1:0];
        n_ptr      = w_go ? w_ptr_wrap : r_ptr;
        n_count    = w_add_ok ? r_count + CNTW'(1) : r_count;

        // an add into an empty table makes the new slot the current one
        if (w_go) begin
            n_cur_ch = r_slot_ch[w_ptr_wrap];
        end else if (w_add_ok && (r_count == '0)) begin
            n_cur_ch = i_op.channel;
        end else begin
            n_cur_ch = r_cur_ch;
        end
    end

    always_comb begin
        o_stat.add_ok           = w_add_ok;
        o_stat.refused          = i_op.add && !w_add_ok;
        o_stat.sample_go        = w_go;
        o_stat.cur_channel      = r_cur_ch;
        o_stat.cur_filter_shift = r_slot_fsh[r_ptr];
        o_stat.next_channel     = n_cur_ch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ptr    <= '0;
            r_cur_ch <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_slot_ch[i]  <= '0;
                r_slot_fsh[i] <= FSH_RESET;
            end
        end else begin
            r_count  <= n_count;
            r_ptr    <= n_ptr;
            r_cur_ch <= n_cur_ch;
            if (w_add_ok) begin
                r_slot_ch[r_count[PW-1:0]]  <= i_op.channel;
                r_slot_fsh[r_count[PW-1:0]] <= i_op.filter_shift;
            end
        end
    end

endmodule

### hw/rtl/asef_chan_store.sv
// ============================================================================
// asef_chan_store
// Per-channel averages and read shifts, with the EMA update datapath.
// ============================================================================
module asef_chan_store
    import asef_pkg::*;
#(
    parameter int CHANNELS = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_op              i_op,
    input  t_scan_stat       i_stat,
    input  logic [SMP_W-1:0] i_sample,
    output logic [VAL_W-1:0] o_value
);

    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [AVG_W-1:0] r_avg [CHANNELS];
    logic [SH_W-1:0]  r_osh [CHANNELS];

    logic              w_rd_ok;
    logic              w_upd;
    logic [CHW-1:0]    w_rd_idx;
    logic [CHW-1:0]    w_cur_idx;
    logic [CHW-1:0]    w_idx;
    logic [AVG_W-1:0]  w_avg;
    logic [AVG_W-1:0]  w_target;
    logic signed [AVG_W:0] w_diff;
    logic signed [AVG_W:0] w_step;
    logic signed [AVG_W:0] w_sum;
    logic [AVG_W-1:0]  w_shifted;

    always_comb begin
        w_rd_idx  = i_op.channel[CHW-1:0];
        w_cur_idx = i_stat.cur_channel[CHW-1:0];
        w_rd_ok   = i_op.rd
                    && ({1'b0, i_op.channel} < (CH_W + 1)'(CHANNELS));
        w_upd     = i_stat.sample_go
                    && ({1'b0, i_stat.cur_channel} < (CH_W + 1)'(CHANNELS));
        w_idx     = i_op.rd ? w_rd_idx : w_cur_idx;
        w_avg     = r_avg[w_idx];

        // avg += floor((target - avg) / 2^fsh); stays within 0..4095<<19
        w_target  = {i_sample, {SAMPLE_SHIFT{1'b0}}};
        w_diff    = $signed({1'b0, w_target}) - $signed({1'b0, w_avg});
        w_step    = w_diff >>> i_stat.cur_filter_shift;
        w_sum     = $signed({1'b0, w_avg}) + w_step;

        w_shifted = w_avg >> r_osh[w_rd_idx];
        o_value   = w_rd_ok ? w_shifted[VAL_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_avg[i] <= '0;
                r_osh[i] <= OSH_RESET;
            end
        end else begin
            if (w_upd) begin
                r_avg[w_cur_idx] <= w_sum[AVG_W-1:0];
            end
            if (i_stat.add_ok) begin
                r_osh[w_rd_idx] <= i_op.out_shift;
            end
        end
    end

endmodule

### hw/rtl/adc_scan_ema_filter_unit.sv
// ============================================================================
// adc_scan_ema_filter_unit
// Round-robin ADC scan sequencer with a per-channel shift low-pass filter.
// ============================================================================
// Each input beat carries a function code in tuser: ADD appends a scan slot
// (channel, filter shift) and sets that channel's read shift, SAMPLE folds a
// 12-bit conversion into the current slot's channel average and steps the
// slot pointer (wrapping at the slot count), READ returns a channel average
// shifted right by its read shift, low 16 bits. Every input beat yields
// exactly one output beat carrying next_channel, the channel to convert next.
// Throughput is one beat per clock while the output is not stalled. Each
// beat passes through the input register, then the table/filter update and
// result register. A stalled output holds both registers. The valid flags,
// scan table and channel store are cleared by reset (the data registers are
// not), so the block is usable as soon as reset is released.
// ============================================================================
module adc_scan_ema_filter_unit
    import asef_pkg::*;
#(
    parameter int SLOTS    = 18,
    parameter int CHANNELS = 18
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // channel[4:0], filter_shift[9:5],
                                     // out_shift[14:10], sample[26:15]
    input  logic [1:0]  i_s_tuser,   // func[1:0]
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // value[15:0], next_channel[20:16]
    output logic [0:0]  o_m_tuser    // refused[0]
);

    // input register
    logic             r_in_valid;
    logic [1:0]       r_in_func;
    logic [CH_W-1:0]  r_in_ch;
    logic [SH_W-1:0]  r_in_fsh;
    logic [SH_W-1:0]  r_in_osh;
    logic [SMP_W-1:0] r_in_smp;

    // result register
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_value;
    logic [CH_W-1:0]  r_out_next;
    logic             r_out_refused;

    logic             w_adv;    // result register can take a new beat
    logic             w_fire;   // input register beat is processed this cycle
    t_op              w_op;
    t_scan_stat       w_stat;
    logic [VAL_W-1:0] w_value;

    assign w_adv      = !r_out_valid || i_m_tready;
    assign w_fire     = r_in_valid && w_adv;
    assign o_s_tready = !r_in_valid || w_adv;

    // decode; state only moves on a processed beat
    always_comb begin
        w_op.add          = 1'b0;
        w_op.sample       = 1'b0;
        w_op.rd           = 1'b0;
        w_op.channel      = r_in_ch;
        w_op.filter_shift = r_in_fsh;
        w_op.out_shift    = r_in_osh;
        case (t_func'(r_in_func))
            FUNC_ADD: begin
                w_op.add = w_fire;
            end
            FUNC_SAMPLE: begin
                w_op.sample = w_fire;
            end
            FUNC_READ: begin
                w_op.rd = w_fire;
            end
            default: begin
                // unused code: no state change, zero value
            end
        endcase
    end

    asef_scan_table #(
        .SLOTS    (SLOTS),
        .CHANNELS (CHANNELS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .o_stat  (w_stat)
    );

    asef_chan_store #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (w_op),
        .i_stat   (w_stat),
        .i_sample (r_in_smp),
        .o_value  (w_value)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_func <= i_s_tuser;
            r_in_ch   <= i_s_tdata[4:0];
            r_in_fsh  <= i_s_tdata[9:5];
            r_in_osh  <= i_s_tdata[14:10];
            r_in_smp  <= i_s_tdata[26:15];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_value   <= w_value;
            r_out_next    <= w_stat.next_channel;
            r_out_refused <= w_stat.refused;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_next, r_out_value};
    assign o_m_tuser  = r_out_refused;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // a refused add never carries a value
    a_refused_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[15:0] == '0))
        else $error("refused beat with nonzero value");

    // next channel always names a real channel
    a_next_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ({1'b0, o_m_tdata[20:16]} < (CH_W + 1)'(CHANNELS)))
        else $error("next_channel out of range");

    // an accepted beat lands in the input register
    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_in_valid)
        else $error("accepted beat lost");

    // a stalled output keeps the pending input beat parked
    a_stall_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_tready) |=> (r_in_valid && o_m_tvalid))
        else $error("beat dropped under backpressure");

endmodule

### dv/tb_adc_scan_ema_filter_unit.sv
// ============================================================================
// tb_adc_scan_ema_filter_unit
// Self-checking bench for the ADC scan sequencer / EMA filter block.
// ============================================================================
// A scoreboard class keeps its own copy of the scan table, read shifts and
// channel averages. It predicts one output beat for every accepted input beat
// and compares each output beat, field by field, with the oldest prediction.
// A short directed sequence covers the special cases: empty table, refused
// adds, out-of-range reads, the spare function code and extreme shifts.
// Random traffic then fills the table while sampling and reading. Both sides
// idle in random bursts, and the last stretch runs with no idling.
// ============================================================================
module tb;
    import asef_pkg::*;

    localparam int SLOTS       = 18;
    localparam int CHANNELS    = 18;
    localparam int RAND_ITEMS  = 480;
    localparam int CALM_ITEMS  = 100;   // tail of the run with no idling
    localparam int QUIET_LIMIT = 2000;  // cycles with no beat on either side
    localparam int TAIL_CYCLES = 8;

    // func code with no operation behind it
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    typedef struct {
        logic [1:0]       func;
        logic [CH_W-1:0]  channel;
        logic [SH_W-1:0]  filter_shift;
        logic [SH_W-1:0]  out_shift;
        logic [SMP_W-1:0] sample;
    } t_scan_item;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic [CH_W-1:0]  next_channel;
        logic             refused;
    } t_readout;

    class ema_scan_scoreboard #(int NUM_SLOTS = 18, int NUM_CH = 18);
        logic [CH_W-1:0]  slot_channel[NUM_SLOTS];
        logic [SH_W-1:0]  slot_filter_shift[NUM_SLOTS];
        logic [SH_W-1:0]  chan_out_shift[NUM_CH];
        logic [AVG_W-1:0] chan_average[NUM_CH];
        int unsigned      slot_count;
        int unsigned      slot_ptr;
        t_readout         pending_readouts[$];
        int unsigned      errors;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_channel[i]      = '0;
                slot_filter_shift[i] = FSH_RESET;
            end
            for (int i = 0; i < NUM_CH; i++) begin
                chan_out_shift[i] = OSH_RESET;
                chan_average[i]   = '0;
            end
            slot_count = 0;
            slot_ptr   = 0;
            errors     = 0;
        endfunction

        // Update the table / averages for one accepted beat, queue its readout.
        function void note_item(t_scan_item it);
            t_readout         r;
            longint           target;
            longint           avg;
            longint           diff;
            logic [AVG_W-1:0] shifted;
            int unsigned      c;
            r.value   = '0;
            r.refused = 1'b0;
            case (it.func)
                FUNC_ADD: begin
                    if (slot_count >= NUM_SLOTS || it.channel >= NUM_CH) begin
                        r.refused = 1'b1;
                    end else begin
                        slot_channel[slot_count]      = it.channel;
                        slot_filter_shift[slot_count] = it.filter_shift;
                        chan_out_shift[it.channel]    = it.out_shift;
                        slot_count++;
                    end
                end
                FUNC_SAMPLE: begin
                    if (slot_count > 0) begin
                        c      = slot_channel[slot_ptr];
                        target = longint'(it.sample) << SAMPLE_SHIFT;
                        avg    = longint'(chan_average[c]);
                        diff   = target - avg;
                        // arithmetic shift on a signed value rounds toward -inf
                        avg    = avg + (diff >>> slot_filter_shift[slot_ptr]);
                        chan_average[c] = avg[AVG_W-1:0];
                        slot_ptr++;
                        if (slot_ptr >= slot_count) slot_ptr = 0;
                    end
                end
                FUNC_READ: begin
                    if (it.channel < NUM_CH) begin
                        shifted = chan_average[it.channel] >> chan_out_shift[it.channel];
                        r.value = shifted[VAL_W-1:0];
                    end
                end
                default: ;
            endcase
            r.next_channel = slot_channel[slot_ptr];
            pending_readouts.push_back(r);
        endfunction

        function void check_readout(logic [23:0] tdata, logic [0:0] tuser);
            t_readout exp_r;
            if (pending_readouts.size() == 0) begin
                $error("output beat with nothing pending: tdata=%h tuser=%b", tdata, tuser);
                errors++;
            end else begin
                exp_r = pending_readouts.pop_front();
                if (tdata[15:0] !== exp_r.value) begin
                    $error("value: expected %h, got %h", exp_r.value, tdata[15:0]);
                    errors++;
                end
                if (tdata[20:16] !== exp_r.next_channel) begin
                    $error("next_channel: expected %0d, got %0d",
                           exp_r.next_channel, tdata[20:16]);
                    errors++;
                end
                if (tuser[0] !== exp_r.refused) begin
                    $error("refused: expected %b, got %b", exp_r.refused, tuser[0]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;   // channel[4:0], filter_shift[9:5], out_shift[14:10],
                              // sample[26:15]
    logic [1:0]  i_s_tuser;   // func[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;   // value[15:0], next_channel[20:16]
    logic [0:0]  o_m_tuser;   // refused[0]

    ema_scan_scoreboard #(SLOTS, CHANNELS) sb;
    bit          src_idles;
    bit          sink_idles;
    int unsigned quiet_cycles;

    adc_scan_ema_filter_unit #(
        .SLOTS    (SLOTS),
        .CHANNELS (CHANNELS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic t_scan_item make_item(logic [1:0] func, int unsigned ch,
                                             int unsigned fsh, int unsigned osh,
                                             int unsigned smp);
        t_scan_item it;
        it.func         = func;
        it.channel      = ch[CH_W-1:0];
        it.filter_shift = fsh[SH_W-1:0];
        it.out_shift    = osh[SH_W-1:0];
        it.sample       = smp[SMP_W-1:0];
        return it;
    endfunction

    function automatic t_scan_item unpack_item(logic [31:0] d, logic [1:0] u);
        t_scan_item it;
        it.func         = u;
        it.channel      = d[4:0];
        it.filter_shift = d[9:5];
        it.out_shift    = d[14:10];
        it.sample       = d[26:15];
        return it;
    endfunction

    // Mostly well-formed traffic: adds while the table has room, then samples
    // and reads, with a sprinkle of refused adds, bad channels and func 3.
    function automatic t_scan_item random_item();
        t_scan_item  it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        it = make_item(FUNC_SAMPLE, $urandom_range(0, CHANNELS - 1), $urandom_range(0, 31),
                       $urandom_range(0, 31), $urandom_range(0, 4095));
        if ($urandom_range(0, 1) == 0) it.filter_shift = SH_W'($urandom_range(0, 10));
        if ($urandom_range(0, 7) == 0) it.sample = ($urandom_range(0, 1) != 0) ? '1 : '0;
        if (sb.slot_count < SLOTS && pick < 10) begin
            it.func = FUNC_ADD;
        end else if (pick < 14) begin
            it.func    = FUNC_ADD;
            it.channel = CH_W'($urandom_range(0, 31));
        end else if (pick < 55) begin
            it.func = FUNC_SAMPLE;
        end else if (pick < 92) begin
            it.func = FUNC_READ;
            if ($urandom_range(0, 7) == 0) it.channel = CH_W'($urandom_range(0, 31));
        end else begin
            it.func    = FUNC_SPARE;
            it.channel = CH_W'($urandom_range(0, 31));
        end
        return it;
    endfunction

    // Present one beat and hold it until accepted.
    task automatic send_item(t_scan_item it);
        int unsigned gap;
        @(negedge i_clk);
        if (src_idles && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  = {5'b0, it.sample, it.out_shift, it.filter_shift, it.channel};
        i_s_tuser  = it.func;
        i_s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic drive_sink();
        int unsigned stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_m_tready = 1'b0;
                stall--;
            end else if (sink_idles && $urandom_range(0, 5) == 0) begin
                stall      = $urandom_range(1, 8) - 1;
                i_m_tready = 1'b0;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.pending_readouts.size() != 0) @(negedge i_clk);
    endtask

    // Output checked before the input beat of the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) sb.check_readout(o_m_tdata, o_m_tuser);
            if (i_s_tvalid && o_s_tready) sb.note_item(unpack_item(i_s_tdata, i_s_tuser));
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $error("watchdog: no beat for %0d cycles", QUIET_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        sb           = new();
        quiet_cycles = 0;
        src_idles    = 1'b1;
        sink_idles   = 1'b1;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        i_m_tready   = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        fork
            drive_sink();
        join_none

        // directed: reset state, empty table, refusals, spare code
        send_item(make_item(FUNC_READ,   0,  0,  0, 0));
        send_item(make_item(FUNC_SAMPLE, 0,  0,  0, 4095));
        send_item(make_item(FUNC_SPARE,  31, 31, 31, 4095));
        send_item(make_item(FUNC_ADD,    18, 3,  3, 0));
        send_item(make_item(FUNC_ADD,    31, 31, 31, 4095));
        send_item(make_item(FUNC_READ,   31, 31, 31, 4095));
        // extreme shifts: filter 0 tracks at once, filter 31 barely moves
        send_item(make_item(FUNC_ADD,    0,  0,  0, 0));
        send_item(make_item(FUNC_SAMPLE, 0,  0,  0, 4095));
        send_item(make_item(FUNC_READ,   0,  0,  0, 0));
        send_item(make_item(FUNC_ADD,    17, 31, 31, 0));
        send_item(make_item(FUNC_SAMPLE, 0,  0,  0, 0));
        send_item(make_item(FUNC_SAMPLE, 0,  0,  0, 4095));
        send_item(make_item(FUNC_ADD,    5,  1,  19, 0));
        send_item(make_item(FUNC_SAMPLE, 0,  0,  0, 4095));
        send_item(make_item(FUNC_SAMPLE, 0,  0,  0, 1));
        send_item(make_item(FUNC_SAMPLE, 0,  0,  0, 2048));
        // negative step on ch5 exercises the floor rounding
        send_item(make_item(FUNC_SAMPLE, 0,  0,  0, 0));
        send_item(make_item(FUNC_SAMPLE, 0,  0,  0, 0));
        send_item(make_item(FUNC_SAMPLE, 0,  0,  0, 3));
        send_item(make_item(FUNC_READ,   5,  0,  0, 0));
        send_item(make_item(FUNC_READ,   17, 0,  0, 0));
        send_item(make_item(FUNC_READ,   0,  0,  0, 0));
        wait_drained();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 2) wait_drained();
            if (n == RAND_ITEMS - CALM_ITEMS) begin
                src_idles  = 1'b0;
                sink_idles = 1'b0;
            end
            send_item(random_item());
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_readouts.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
